### rtl/mbrs_pkg.sv
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU slave responder.
// Has no dependencies. Every module in rtl/ imports it.
package mbrs_pkg;

    typedef enum logic [2:0] {
        OP_SEND  = 3'd0,
        OP_RECV  = 3'd1,
        OP_OPEN  = 3'd2,
        OP_CLOSE = 3'd3,
        OP_POKE  = 3'd4,
        OP_PEEK  = 3'd5
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  fbyte;
        logic        flast;
        logic [15:0] addr;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctl_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_POP,
        S_PEEK,
        S_SERVE,
        S_EMIT,
        S_RD_ADDR,
        S_RD_HI,
        S_RD_LO,
        S_WM_RD,
        S_WM_LO,
        S_WM_WR,
        S_CRC_LO,
        S_CRC_HI,
        S_RESULT
    } state_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CLOSED    = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BAD_FN    = 3'd3;
    localparam logic [2:0] ST_COUNT_ERR = 3'd4;
    localparam logic [2:0] ST_RANGE     = 3'd5;
    localparam logic [2:0] ST_DLT645    = 3'd6;

    localparam logic [7:0] FN_READ_HOLD  = 8'h03;
    localparam logic [7:0] FN_READ_INPUT = 8'h04;
    localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY = 8'h10;
    localparam logic [7:0] DLT_START     = 8'h68;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] x;
        x = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

### rtl/mbrs_front.sv
// Front end: accepts input items, classifies the action and queues them for the back end.
// Depends on mbrs_pkg.
module mbrs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        action,
    input  logic [7:0]        frame_byte,
    input  logic              frame_last,
    input  logic [15:0]       reg_address,
    input  logic [15:0]       reg_value,
    input  mbrs_pkg::back_ctl_t ctl,
    output logic              q_valid,
    output mbrs_pkg::item_t   q_item
);
    import mbrs_pkg::*;

    item_t      q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       known_op;
    logic       push;
    item_t      in_item;

    // Unused action codes are swallowed here and never reach the back end.
    always_comb
    begin
        unique case (action) inside
            OP_SEND, OP_RECV, OP_OPEN, OP_CLOSE, OP_POKE, OP_PEEK: known_op = 1'b1;
            default: known_op = 1'b0;
        endcase
    end

    assign in_item  = '{op: op_t'(action), fbyte: frame_byte, flast: frame_last,
                       addr: reg_address, value: reg_value};
    assign in_stall = (cnt_reg == 2'd2) || ctl.clearing;
    assign push     = in_valid && !in_stall && known_op;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (ctl.pop)
                rp_reg <= ~rp_reg;
            if (push && !ctl.pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!push && ctl.pop)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= in_item;
    end

endmodule

### rtl/mbrs_back.sv
// Back end: sequencer that executes queued items, holds the register store, request and
// response buffers, builds responses with CRC-16/MODBUS and drives the result register.
// Depends on mbrs_pkg.
module mbrs_back #(
    parameter int REG_DEPTH      = 1024,
    parameter int FRAME_DEPTH    = 256,
    parameter int RESP_DEPTH     = 256,
    parameter int MAX_READ_COUNT = 125
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  mbrs_pkg::item_t     q_item,
    output mbrs_pkg::back_ctl_t ctl,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          status,
    output logic [7:0]          data_byte,
    output logic                byte_valid,
    output logic                last_byte,
    output logic [15:0]         peek_value
);
    import mbrs_pkg::*;

    localparam int REG_AW = $clog2(REG_DEPTH);
    localparam int FI_W   = $clog2(FRAME_DEPTH);
    localparam int FL_W   = $clog2(FRAME_DEPTH + 2);
    localparam int RI_W   = $clog2(RESP_DEPTH);
    localparam int RL_W   = $clog2(RESP_DEPTH + 1);
    localparam logic [16:0]       REG_LIMIT   = 17'(REG_DEPTH);
    localparam logic [FL_W-1:0]   FRAME_LIMIT = FL_W'(FRAME_DEPTH);
    localparam logic [REG_AW-1:0] CLR_LAST    = REG_AW'(REG_DEPTH - 1);

    // Memories
    logic [15:0] reg_mem  [REG_DEPTH];
    logic [7:0]  req_mem  [FRAME_DEPTH];
    logic [7:0]  resp_mem [RESP_DEPTH];

    logic              reg_we, reg_re;
    logic [REG_AW-1:0] reg_wa, reg_ra;
    logic [15:0]       reg_wd, reg_q;
    logic              req_we, req_re;
    logic [FI_W-1:0]   req_wa, req_ra;
    logic [7:0]        req_wd, req_q;
    logic              resp_we, resp_re;
    logic [RI_W-1:0]   resp_wa, resp_ra;
    logic [7:0]        resp_wd, resp_q;

    // Control and datapath registers
    state_t            state_reg, state_next;
    logic              port_open_reg, port_open_next;
    logic [FL_W-1:0]   req_len_reg, req_len_next;
    logic [FL_W-1:0]   flen_reg, flen_next;
    logic [7:0]        hdr_reg [8];
    logic [7:0]        hdr_next [8];
    logic [RL_W-1:0]   resp_head_reg, resp_head_next;
    logic [RL_W-1:0]   resp_len_reg, resp_len_next;
    logic [RL_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [15:0]       crc_reg, crc_next;
    logic [2:0]        k_reg, k_next;
    logic              echo_reg, echo_next;
    logic [15:0]       idx_reg, idx_next;
    logic [FI_W-1:0]   rofs_reg, rofs_next;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        hi_reg, hi_next;
    logic              inr_reg, inr_next;
    item_t             cur_reg, cur_next;
    logic [REG_AW-1:0] clr_reg, clr_next;
    logic [2:0]        res_status_reg, res_status_next;
    logic [7:0]        res_data_reg, res_data_next;
    logic              res_valid_reg, res_valid_next;
    logic              res_last_reg, res_last_next;
    logic [15:0]       res_peek_reg, res_peek_next;
    logic              out_valid_reg;
    logic [2:0]        out_status_reg;
    logic [7:0]        out_data_reg;
    logic              out_bvalid_reg, out_last_reg;
    logic [15:0]       out_peek_reg;

    // Decoded conditions
    logic [7:0]  fn;
    logic [15:0] base_addr, count;
    logic [16:0] addr_i, count2;
    logic        addr_i_ok, cur_ok;
    logic        rd_fn, rd_too_big, wm_bad, is_dlt, last_idx, emit_end, have_byte;
    logic        frame_long, frame_short, out_free, load_out;
    logic [7:0]  emit_byte;
    logic [15:0] rd_val;

    assign fn          = hdr_reg[1];
    assign base_addr   = {hdr_reg[2], hdr_reg[3]};
    assign count       = {hdr_reg[4], hdr_reg[5]};
    assign count2      = {count, 1'b0};
    assign addr_i      = {1'b0, base_addr} + {1'b0, idx_reg};
    assign addr_i_ok   = addr_i < REG_LIMIT;
    assign cur_ok      = {1'b0, cur_reg.addr} < REG_LIMIT;
    assign rd_fn       = (fn == FN_READ_HOLD) || (fn == FN_READ_INPUT);
    assign rd_too_big  = (count > 16'(MAX_READ_COUNT))
                      || ((18'd5 + {1'b0, count2}) > 18'(RESP_DEPTH));
    assign wm_bad      = ({9'd0, hdr_reg[6]} != count2)
                      || ((18'd7 + {1'b0, count2}) > 18'(flen_reg));
    assign frame_long  = flen_reg > FRAME_LIMIT;
    assign frame_short = flen_reg < FL_W'(8);
    assign is_dlt      = (flen_reg >= FL_W'(12)) && (hdr_reg[0] == DLT_START)
                      && (hdr_reg[7] == DLT_START);
    assign last_idx    = (idx_reg + 16'd1) == count;
    assign emit_end    = echo_reg ? (k_reg == 3'd5) : (k_reg == 3'd2);
    // A read response starts with address, function and the byte count modulo 256.
    assign emit_byte   = (!echo_reg && k_reg == 3'd2) ? {count[6:0], 1'b0} : hdr_reg[k_reg];
    assign have_byte   = resp_head_reg < resp_len_reg;
    assign rd_val      = inr_reg ? reg_q : 16'h0000;
    assign out_free    = !out_valid_reg || !out_stall;
    assign load_out    = (state_reg == S_RESULT) && out_free;

    assign ctl.pop      = (state_reg == S_IDLE) && q_valid;
    assign ctl.clearing = (state_reg == S_CLEAR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (clr_reg == CLR_LAST) state_next = S_IDLE;
            S_IDLE:    if (q_valid) state_next = S_EXEC;
            S_EXEC:
            begin
                unique case (cur_reg.op)
                    OP_SEND:
                    begin
                        if (!port_open_reg)    state_next = S_RESULT;
                        else if (cur_reg.flast) state_next = S_SERVE;
                        else                    state_next = S_IDLE;
                    end
                    OP_RECV:
                    begin
                        if (port_open_reg && have_byte) state_next = S_POP;
                        else                            state_next = S_RESULT;
                    end
                    OP_PEEK:   state_next = S_PEEK;
                    default:   state_next = S_RESULT;
                endcase
            end
            S_POP:     state_next = S_RESULT;
            S_PEEK:    state_next = S_RESULT;
            S_SERVE:
            begin
                if (frame_long || is_dlt || frame_short)
                    state_next = S_RESULT;
                else if (rd_fn)
                    state_next = rd_too_big ? S_RESULT : S_EMIT;
                else if (fn == FN_WRITE_ONE)
                    state_next = S_EMIT;
                else if (fn == FN_WRITE_MANY)
                begin
                    if (wm_bad)              state_next = S_RESULT;
                    else if (count == 16'd0) state_next = S_EMIT;
                    else                     state_next = S_WM_RD;
                end
                else
                    state_next = S_RESULT;
            end
            S_EMIT:
            begin
                if (emit_end)
                    state_next = (echo_reg || count == 16'd0) ? S_CRC_LO : S_RD_ADDR;
            end
            S_RD_ADDR: state_next = S_RD_HI;
            S_RD_HI:   state_next = S_RD_LO;
            S_RD_LO:   state_next = last_idx ? S_CRC_LO : S_RD_ADDR;
            S_WM_RD:   state_next = S_WM_LO;
            S_WM_LO:   state_next = S_WM_WR;
            S_WM_WR:   state_next = last_idx ? S_EMIT : S_WM_RD;
            S_CRC_LO:  state_next = S_CRC_HI;
            S_CRC_HI:  state_next = S_RESULT;
            S_RESULT:  if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        port_open_next  = port_open_reg;
        req_len_next    = req_len_reg;
        flen_next       = flen_reg;
        hdr_next        = hdr_reg;
        resp_head_next  = resp_head_reg;
        resp_len_next   = resp_len_reg;
        wr_ptr_next     = wr_ptr_reg;
        crc_next        = crc_reg;
        k_next          = k_reg;
        echo_next       = echo_reg;
        idx_next        = idx_reg;
        rofs_next       = rofs_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        inr_next        = inr_reg;
        cur_next        = cur_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_valid_next  = res_valid_reg;
        res_last_next   = res_last_reg;
        res_peek_next   = res_peek_reg;
        reg_we  = 1'b0;
        reg_wa  = '0;
        reg_wd  = '0;
        reg_re  = 1'b0;
        reg_ra  = '0;
        req_we  = 1'b0;
        req_wa  = req_len_reg[FI_W-1:0];
        req_wd  = cur_reg.fbyte;
        req_re  = 1'b0;
        req_ra  = rofs_reg;
        resp_we = 1'b0;
        resp_wa = wr_ptr_reg[RI_W-1:0];
        resp_wd = emit_byte;
        resp_re = 1'b0;
        resp_ra = resp_head_reg[RI_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                reg_we   = 1'b1;
                reg_wa   = clr_reg;
                clr_next = clr_reg + REG_AW'(1);
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next        = q_item;
                    res_status_next = ST_OK;
                    res_data_next   = 8'h00;
                    res_valid_next  = 1'b0;
                    res_last_next   = 1'b0;
                    res_peek_next   = 16'h0000;
                end
            end
            S_EXEC:
            begin
                case (cur_reg.op)
                    OP_SEND:
                    begin
                        if (!port_open_reg)
                        begin
                            req_len_next    = '0;
                            res_status_next = ST_CLOSED;
                        end
                        else
                        begin
                            if (req_len_reg < FRAME_LIMIT)
                            begin
                                req_we       = 1'b1;
                                req_len_next = req_len_reg + FL_W'(1);
                                if (req_len_reg < FL_W'(8))
                                    hdr_next[req_len_reg[2:0]] = cur_reg.fbyte;
                            end
                            else
                                req_len_next = FRAME_LIMIT + FL_W'(1);
                            if (cur_reg.flast)
                            begin
                                flen_next    = req_len_next;
                                req_len_next = '0;
                            end
                        end
                    end
                    OP_RECV:
                    begin
                        if (!port_open_reg)
                            res_status_next = ST_CLOSED;
                        else if (have_byte)
                            resp_re = 1'b1;
                    end
                    OP_OPEN:  port_open_next = 1'b1;
                    OP_CLOSE:
                    begin
                        port_open_next = 1'b0;
                        resp_head_next = '0;
                        resp_len_next  = '0;
                        req_len_next   = '0;
                    end
                    OP_POKE:
                    begin
                        reg_we = cur_ok;
                        reg_wa = cur_reg.addr[REG_AW-1:0];
                        reg_wd = cur_reg.value;
                    end
                    OP_PEEK:
                    begin
                        reg_re   = 1'b1;
                        reg_ra   = cur_reg.addr[REG_AW-1:0];
                        inr_next = cur_ok;
                    end
                    default: ;
                endcase
            end
            S_POP:
            begin
                res_data_next  = resp_q;
                res_valid_next = 1'b1;
                res_last_next  = (resp_head_reg + RL_W'(1)) >= resp_len_reg;
                resp_head_next = resp_head_reg + RL_W'(1);
            end
            S_PEEK:    res_peek_next = rd_val;
            S_SERVE:
            begin
                wr_ptr_next = '0;
                crc_next    = CRC_INIT;
                k_next      = 3'd0;
                idx_next    = 16'd0;
                rofs_next   = FI_W'(7);
                echo_next   = !rd_fn;
                if (frame_long)
                    res_status_next = ST_RANGE;
                else if (is_dlt)
                begin
                    resp_head_next  = '0;
                    resp_len_next   = '0;
                    res_status_next = ST_DLT645;
                end
                else if (frame_short)
                    res_status_next = ST_SHORT;
                else
                begin
                    resp_head_next = '0;
                    resp_len_next  = '0;
                    if (rd_fn)
                    begin
                        if (rd_too_big)
                            res_status_next = ST_RANGE;
                    end
                    else if (fn == FN_WRITE_ONE)
                    begin
                        reg_we = ({1'b0, base_addr} < REG_LIMIT);
                        reg_wa = base_addr[REG_AW-1:0];
                        reg_wd = count;
                    end
                    else if (fn == FN_WRITE_MANY)
                    begin
                        if (wm_bad)
                            res_status_next = ST_COUNT_ERR;
                    end
                    else
                        res_status_next = ST_BAD_FN;
                end
            end
            S_EMIT:
            begin
                resp_we     = 1'b1;
                crc_next    = crc16_byte(crc_reg, emit_byte);
                wr_ptr_next = wr_ptr_reg + RL_W'(1);
                k_next      = k_reg + 3'd1;
            end
            S_RD_ADDR:
            begin
                reg_re   = 1'b1;
                reg_ra   = addr_i[REG_AW-1:0];
                inr_next = addr_i_ok;
            end
            S_RD_HI:
            begin
                resp_we     = 1'b1;
                resp_wd     = rd_val[15:8];
                crc_next    = crc16_byte(crc_reg, rd_val[15:8]);
                lo_next     = rd_val[7:0];
                wr_ptr_next = wr_ptr_reg + RL_W'(1);
            end
            S_RD_LO:
            begin
                resp_we     = 1'b1;
                resp_wd     = lo_reg;
                crc_next    = crc16_byte(crc_reg, lo_reg);
                wr_ptr_next = wr_ptr_reg + RL_W'(1);
                idx_next    = idx_reg + 16'd1;
            end
            S_WM_RD:   req_re = 1'b1;
            S_WM_LO:
            begin
                hi_next = req_q;
                req_re  = 1'b1;
                req_ra  = rofs_reg + FI_W'(1);
            end
            S_WM_WR:
            begin
                reg_we    = addr_i_ok;
                reg_wa    = addr_i[REG_AW-1:0];
                reg_wd    = {hi_reg, req_q};
                idx_next  = idx_reg + 16'd1;
                rofs_next = rofs_reg + FI_W'(2);
            end
            S_CRC_LO:
            begin
                resp_we     = 1'b1;
                resp_wd     = crc_reg[7:0];
                wr_ptr_next = wr_ptr_reg + RL_W'(1);
            end
            S_CRC_HI:
            begin
                resp_we        = 1'b1;
                resp_wd        = crc_reg[15:8];
                resp_len_next  = wr_ptr_reg + RL_W'(1);
                resp_head_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            port_open_reg <= 1'b0;
            req_len_reg   <= '0;
            resp_head_reg <= '0;
            resp_len_reg  <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            port_open_reg <= port_open_next;
            req_len_reg   <= req_len_next;
            resp_head_reg <= resp_head_next;
            resp_len_reg  <= resp_len_next;
            clr_reg       <= clr_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        flen_reg       <= flen_next;
        hdr_reg        <= hdr_next;
        wr_ptr_reg     <= wr_ptr_next;
        crc_reg        <= crc_next;
        k_reg          <= k_next;
        echo_reg       <= echo_next;
        idx_reg        <= idx_next;
        rofs_reg       <= rofs_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        inr_reg        <= inr_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_valid_reg  <= res_valid_next;
        res_last_reg   <= res_last_next;
        res_peek_reg   <= res_peek_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_data_reg   <= res_data_reg;
            out_bvalid_reg <= res_valid_reg;
            out_last_reg   <= res_last_reg;
            out_peek_reg   <= res_peek_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (reg_we)
            reg_mem[reg_wa] <= reg_wd;
        if (reg_re)
            reg_q <= reg_mem[reg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (req_we)
            req_mem[req_wa] <= req_wd;
        if (req_re)
            req_q <= req_mem[req_ra];
    end

    always_ff @(posedge clk)
    begin
        if (resp_we)
            resp_mem[resp_wa] <= resp_wd;
        if (resp_re)
            resp_q <= resp_mem[resp_ra];
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign data_byte  = out_data_reg;
    assign byte_valid = out_bvalid_reg;
    assign last_byte  = out_last_reg;
    assign peek_value = out_peek_reg;

    a_head_within_len: assert property (@(posedge clk) disable iff (!rst_n)
        resp_head_reg <= resp_len_reg)
        else $error("response head ran past response length");

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !ctl.pop)
        else $error("item taken during the store clearing pass");

    a_req_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        req_len_reg <= FRAME_LIMIT + FL_W'(1))
        else $error("request length out of bounds");

    a_result_loaded_once: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (state_reg == S_IDLE) && out_valid_reg)
        else $error("result register not loaded on leaving result state");

endmodule

### rtl/modbus_rtu_slave_responder.sv
// Modbus RTU slave responder: accepts one action per item and returns at most one result
// item per action. After reset the holding register store is cleared by a pass over every
// address during which in_stall stays high. A non-final request byte to an open port is
// only stored; open, close, poke and a receive that pops nothing go from execute to the
// result state; peek and a receive that pops a byte pass a read state first. On the final
// request byte the frame is served by the register store and a byte-wide CRC step: header
// bytes are emitted, a read then fetches each register and writes its high and low byte,
// a write of many first stores each register, and the CRC low and high bytes close the
// response; a rejected frame goes straight to the result state. A two-item queue in front
// and a result register behind let both sides stall independently.
// Depends on mbrs_pkg, mbrs_front and mbrs_back.
module modbus_rtu_slave_responder #(
    parameter int REG_DEPTH      = 1024,
    parameter int FRAME_DEPTH    = 256,
    parameter int RESP_DEPTH     = 256,
    parameter int MAX_READ_COUNT = 125
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic [15:0] reg_address,
    input  logic [15:0] reg_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  data_byte,
    output logic        byte_valid,
    output logic        last_byte,
    output logic [15:0] peek_value
);
    import mbrs_pkg::*;

    back_ctl_t ctl;
    logic      q_valid;
    item_t     q_item;

    mbrs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .frame_byte  (frame_byte),
        .frame_last  (frame_last),
        .reg_address (reg_address),
        .reg_value   (reg_value),
        .ctl         (ctl),
        .q_valid     (q_valid),
        .q_item      (q_item)
    );

    mbrs_back #(
        .REG_DEPTH      (REG_DEPTH),
        .FRAME_DEPTH    (FRAME_DEPTH),
        .RESP_DEPTH     (RESP_DEPTH),
        .MAX_READ_COUNT (MAX_READ_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .peek_value (peek_value)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for the Modbus RTU slave responder: a behavioral model of the
// register store, request framing and CRC-sealed response queue predicts each result item.
// Depends on mbrs_pkg and modbus_rtu_slave_responder.
`timescale 1ns / 100ps

import mbrs_pkg::*;

class modbus_scoreboard;
    localparam int NREGS = 1024;
    localparam int FDEPTH = 256;
    localparam int RDEPTH = 256;
    localparam int MAXRD = 125;

    bit          is_open;
    logic [7:0]  req_bytes[FDEPTH];
    int          req_len;
    logic [7:0]  resp_bytes[RDEPTH];
    int          resp_head;
    int          resp_len;
    logic [15:0] holding[NREGS];
    logic [2:0]  exp_status[$];
    logic [7:0]  exp_data[$];
    logic        exp_bvalid[$];
    logic        exp_last[$];
    logic [15:0] exp_peek[$];
    int          errors;
    int          checked;

    function new();
        is_open = 0;
        req_len = 0;
        resp_head = 0;
        resp_len = 0;
        errors = 0;
        checked = 0;
        foreach (holding[i]) holding[i] = '0;
    endfunction

    function logic [15:0] read_reg(int a);
        return (a < NREGS) ? holding[a] : 16'h0;
    endfunction

    function void write_reg(int a, logic [15:0] v);
        if (a < NREGS) holding[a] = v;
    endfunction

    function int req_word(int off);
        return {req_bytes[off], req_bytes[off + 1]};
    endfunction

    function void seal(int n);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            crc ^= {8'h00, resp_bytes[i]};
            for (int b = 0; b < 8; b++)
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        resp_bytes[n] = crc[7:0];
        resp_bytes[n + 1] = crc[15:8];
        resp_len = n + 2;
        resp_head = 0;
    endfunction

    function void echo();
        for (int i = 0; i < 6; i++) resp_bytes[i] = req_bytes[i];
        seal(6);
    endfunction

    function logic [2:0] serve_frame(int len);
        int fn;
        int addr;
        int cnt;
        if (len > FDEPTH) return ST_RANGE;
        if (len >= 12 && req_bytes[0] == DLT_START && req_bytes[7] == DLT_START)
        begin
            resp_head = 0;
            resp_len = 0;
            return ST_DLT645;
        end
        if (len < 8) return ST_SHORT;
        resp_head = 0;
        resp_len = 0;
        fn = req_bytes[1];
        addr = req_word(2);
        cnt = req_word(4);
        if (fn == FN_READ_HOLD || fn == FN_READ_INPUT)
        begin
            if (cnt > MAXRD || 5 + 2 * cnt > RDEPTH) return ST_RANGE;
            resp_bytes[0] = req_bytes[0];
            resp_bytes[1] = fn[7:0];
            resp_bytes[2] = 8'((cnt * 2) & 255);
            for (int i = 0; i < cnt; i++)
            begin
                logic [15:0] v;
                v = read_reg(addr + i);
                resp_bytes[3 + 2 * i] = v[15:8];
                resp_bytes[4 + 2 * i] = v[7:0];
            end
            seal(3 + 2 * cnt);
            return ST_OK;
        end
        if (fn == FN_WRITE_ONE)
        begin
            write_reg(addr, cnt[15:0]);
            echo();
            return ST_OK;
        end
        if (fn == FN_WRITE_MANY)
        begin
            if (req_bytes[6] != cnt * 2 || 7 + 2 * cnt > len) return ST_COUNT_ERR;
            for (int i = 0; i < cnt; i++) write_reg(addr + i, req_word(7 + 2 * i));
            echo();
            return ST_OK;
        end
        return ST_BAD_FN;
    endfunction

    // Notes one accepted item and queues the result it causes, if any.
    function void note_item(logic [2:0] act, logic [7:0] fb, logic fl,
                            logic [15:0] ra, logic [15:0] rv);
        logic [2:0]  st;
        logic [7:0]  d;
        logic        bv;
        logic        lb;
        logic [15:0] pk;
        st = ST_OK;
        d = 0;
        bv = 0;
        lb = 0;
        pk = 0;
        case (act)
            OP_SEND:
            begin
                if (!is_open)
                begin
                    req_len = 0;
                    st = ST_CLOSED;
                end
                else
                begin
                    if (req_len < FDEPTH)
                    begin
                        req_bytes[req_len] = fb;
                        req_len++;
                    end
                    else
                        req_len = FDEPTH + 1;
                    if (!fl) return;
                    st = serve_frame(req_len);
                    req_len = 0;
                end
            end
            OP_RECV:
            begin
                if (!is_open)
                    st = ST_CLOSED;
                else if (resp_head < resp_len && resp_head < RDEPTH)
                begin
                    d = resp_bytes[resp_head];
                    resp_head++;
                    bv = 1;
                    lb = (resp_head >= resp_len);
                end
            end
            OP_OPEN: is_open = 1;
            OP_CLOSE:
            begin
                is_open = 0;
                resp_head = 0;
                resp_len = 0;
                req_len = 0;
            end
            OP_POKE: write_reg(ra, rv);
            OP_PEEK: pk = read_reg(ra);
            default: return;
        endcase
        exp_status = {exp_status, st};
        exp_data = {exp_data, d};
        exp_bvalid = {exp_bvalid, bv};
        exp_last = {exp_last, lb};
        exp_peek = {exp_peek, pk};
    endfunction

    function int pending();
        return exp_status.size();
    endfunction

    task report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    task check_result(logic [2:0] st, logic [7:0] d, logic bv, logic lb, logic [15:0] pk);
        logic [2:0] es;
        logic [7:0] ed;
        logic       ebv;
        logic       elb;
        logic [15:0] epk;
        checked++;
        if (exp_status.size() == 0)
        begin
            report("unexpected result", st, 0);
            return;
        end
        es = exp_status.pop_front();
        ed = exp_data.pop_front();
        ebv = exp_bvalid.pop_front();
        elb = exp_last.pop_front();
        epk = exp_peek.pop_front();
        if (st !== es) report("status", st, es);
        if (d !== ed) report("data_byte", d, ed);
        if (bv !== ebv) report("byte_valid", bv, ebv);
        if (lb !== elb) report("last_byte", lb, elb);
        if (pk !== epk) report("peek_value", pk, epk);
    endtask
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_byte;
    logic [15:0] peek_value;

    modbus_scoreboard board;
    int  idle_pct;
    int  stall_pct;
    int  cycles;
    int  items_sent;
    int  frames_sent;

    modbus_rtu_slave_responder dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .frame_byte(frame_byte), .frame_last(frame_last),
        .reg_address(reg_address), .reg_value(reg_value), .out_valid(out_valid),
        .out_stall(out_stall), .status(status), .data_byte(data_byte),
        .byte_valid(byte_valid), .last_byte(last_byte), .peek_value(peek_value)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Checks results as they are accepted and drives the receiver's stall.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(status, data_byte, byte_valid, last_byte, peek_value);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task send_item(logic [2:0] act, logic [7:0] fb, logic fl, logic [15:0] ra,
                   logic [15:0] rv);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        frame_byte <= fb;
        frame_last <= fl;
        reg_address <= ra;
        reg_value <= rv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(act, fb, fl, ra, rv);
        items_sent++;
    endtask

    task send_frame(logic [7:0] bytes[$]);
        foreach (bytes[i]) send_item(OP_SEND, bytes[i], i == bytes.size() - 1,
                                     16'($urandom), 16'($urandom));
        frames_sent++;
    endtask

    task drain_response();
        int n;
        n = board.resp_len - board.resp_head + 1;
        repeat (n) send_item(OP_RECV, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task wait_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
    endtask

    // A request frame with a random CRC trailer; func and mode pick the shape.
    task build_request(int func, int ad, int cnt, int mode, output logic [7:0] f[$]);
        f = {8'($urandom), 8'(func), 8'(ad >> 8), 8'(ad), 8'(cnt >> 8), 8'(cnt)};
        if (func == FN_WRITE_MANY)
        begin
            f = {f, (mode == 1 ? 8'($urandom) : 8'(cnt * 2))};
            for (int i = 0; i < 2 * cnt - (mode == 2 ? 1 : 0); i++) f = {f, 8'($urandom)};
        end
        f = {f, 8'($urandom)};
        f = {f, 8'($urandom)};
    endtask

    task random_transaction();
        logic [7:0] f[$];
        int  pick;
        int  ad;
        int  cnt;
        pick = $urandom_range(99);
        ad = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(1040);
        cnt = ($urandom_range(15) == 0) ? $urandom_range(130) : $urandom_range(8);
        if (pick < 25)
            build_request(FN_READ_HOLD + $urandom_range(1), ad, cnt, 0, f);
        else if (pick < 40)
            build_request(FN_WRITE_ONE, ad, $urandom_range(65535), 0, f);
        else if (pick < 55)
            build_request(FN_WRITE_MANY, ad, cnt, ($urandom_range(9) == 0) ? 1 + $urandom_range(1) : 0, f);
        else if (pick < 62)
        begin
            f = {};
            repeat ($urandom_range(12)) f = {f, 8'($urandom)};
            f = {f, 8'($urandom)};
        end
        else if (pick < 70)
            send_item(OP_POKE, 8'($urandom), 1'($urandom), 16'($urandom_range(1100)), 16'($urandom));
        else if (pick < 78)
            send_item(OP_PEEK, 8'($urandom), 1'($urandom), 16'($urandom_range(1100)), 16'($urandom));
        else if (pick < 90)
            send_item(OP_RECV, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 94)
            send_item(OP_CLOSE, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        else if (pick < 98)
            send_item(OP_OPEN, 8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
        else
            send_item(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom));
        if (f.size() != 0)
        begin
            send_frame(f);
            if ($urandom_range(3) != 0) drain_response();
        end
    endtask

    initial
    begin
        logic [7:0] f[$];
        board = new();
        items_sent = 0;
        frames_sent = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = OP_OPEN;
        frame_byte = 0;
        frame_last = 0;
        reg_address = 0;
        reg_value = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: closed-port traffic, then every frame kind and extreme.
        send_item(OP_SEND, 8'hFF, 1'b1, 16'h0, 16'h0);
        send_item(OP_RECV, 8'h00, 1'b0, 16'h0, 16'h0);
        send_item(OP_POKE, 8'h00, 1'b0, 16'd1023, 16'hFFFF);
        send_item(OP_POKE, 8'h00, 1'b0, 16'hFFFF, 16'h1234);
        send_item(OP_PEEK, 8'h00, 1'b0, 16'd1023, 16'h0);
        send_item(OP_PEEK, 8'h00, 1'b0, 16'hFFFF, 16'h0);
        send_item(OP_OPEN, 8'h00, 1'b0, 16'h0, 16'h0);
        build_request(FN_READ_HOLD, 1020, 6, 0, f);
        send_frame(f);
        drain_response();
        build_request(FN_READ_INPUT, 0, 126, 0, f);
        send_frame(f);
        build_request(FN_WRITE_ONE, 65535, 16'hABCD, 0, f);
        send_frame(f);
        drain_response();
        build_request(FN_WRITE_MANY, 1022, 3, 0, f);
        send_frame(f);
        build_request(FN_WRITE_MANY, 5, 2, 1, f);
        send_frame(f);
        build_request(FN_WRITE_MANY, 5, 2, 2, f);
        send_frame(f);
        f = {8'h68, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(f);
        f = {8'h01, 8'h07, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00};
        send_frame(f);
        f = {8'h01, 8'h03, 8'h00};
        send_frame(f);
        f = {};
        repeat (300) f = {f, 8'($urandom)};
        send_frame(f);
        send_item(OP_CLOSE, 8'h00, 1'b0, 16'h0, 16'h0);
        send_item(3'd7, 8'h00, 1'b0, 16'h0, 16'h0);
        send_item(OP_OPEN, 8'h00, 1'b0, 16'h0, 16'h0);
        wait_empty();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 80 : 26) : 0;
            stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 80 : 26) : 0;
            while (items_sent < 60 + 260 * (phase + 1))
                random_transaction();
            wait_empty();
        end

        in_valid <= 1'b0;
        repeat (500) @(posedge clk);
        $display("covered %0d items in %0d frames, %0d results checked",
                 items_sent, frames_sent, board.checked);
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
